/* rtl/annexb_to_length_prefixed_nal_core_defines.svh */
// Assertion macros shared by the Annex B to length-prefixed NAL RTL.
// No dependencies; the assertions drop out when SYNTHESIS is defined.
`ifndef ANNEXB_TO_LENGTH_PREFIXED_NAL_CORE_DEFINES_SVH
`define ANNEXB_TO_LENGTH_PREFIXED_NAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define ANB2L_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ANB2L_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ANB2L_ASSERT_NOW(label, clk, rst, ante, cons)
`define ANB2L_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/anb2l_pkg.sv */
// Types and fixed constants for the Annex B to length-prefixed NAL converter.
// No dependencies.
`default_nettype none
package anb2l_pkg;
   localparam int TYPE_BITS    = 5;
   localparam int FRAME_BITS   = 26;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [FRAME_BITS-1:0]    FRAME_MAX       = '1;
   localparam logic [CSR_DATA_BITS-1:0] DROP_MASK_RESET = 32'h0000_0380;
   localparam logic [7:0]               ZERO_BYTE       = 8'h00;
   localparam logic [7:0]               START_CODE_BYTE = 8'h01;
   localparam logic [2:0]               PREFIX_BYTES    = 3'd4;
   localparam logic [1:0]               HELD_FULL       = 2'd3;

   // Register index, taken from paddr above the byte lanes
   localparam logic CSR_IDX_DROP_MASK = 1'b0;

   typedef struct packed {
      logic [1:0]           held;
      logic                 in_nal;
      logic                 awaiting;
      logic                 keep;
      logic [TYPE_BITS-1:0] ctype;
   } nal_state_type;

   typedef struct packed {
      logic [2:0] zero_cnt;
      logic       byte_vld;
      logic       rec_vld;
      logic       rec_fe;
   } bundle_ctl_type;
endpackage
`default_nettype wire

/* rtl/anb2l_step.sv */
// Per-byte parser step: start-code detection, NAL type filter, length and
// frame total update, and the bundle of results for one byte. Uses anb2l_pkg.
`default_nettype none
module anb2l_step #(
   parameter int LEN_BITS = 24
) (
   input  wire logic [7:0]                            data_byte,
   input  wire logic                                  frame_last,
   input  wire logic [anb2l_pkg::CSR_DATA_BITS-1:0]   drop_mask,
   input  wire anb2l_pkg::nal_state_type              st_cur,
   input  wire logic [LEN_BITS-1:0]                   len_cur,
   input  wire logic [anb2l_pkg::FRAME_BITS-1:0]      ftot_cur,
   output anb2l_pkg::nal_state_type                   st_nxt,
   output logic [LEN_BITS-1:0]                        len_nxt,
   output logic [anb2l_pkg::FRAME_BITS-1:0]           ftot_nxt,
   output anb2l_pkg::bundle_ctl_type                  bnd_ctl,
   output logic [LEN_BITS-1:0]                        bnd_len,
   output logic [anb2l_pkg::TYPE_BITS-1:0]            bnd_type,
   output logic [anb2l_pkg::FRAME_BITS-1:0]           bnd_fs
);
   localparam int SUM_BITS =
      ((LEN_BITS > anb2l_pkg::FRAME_BITS) ? LEN_BITS : anb2l_pkg::FRAME_BITS) + 2;

   anb2l_pkg::nal_state_type st_h;
   anb2l_pkg::nal_state_type st_m;
   logic [LEN_BITS-1:0]   len_h;
   logic                  is_sc;
   logic [2:0]            zeros_a;
   logic [2:0]            zeros_b;
   logic [2:0]            zeros_tot;
   logic                  byte_v;
   logic [2:0]            inc;
   logic [LEN_BITS:0]     len_sum;
   logic [LEN_BITS-1:0]   len_new;
   logic                  close_kept;
   logic [LEN_BITS-1:0]   close_len;
   logic [SUM_BITS-1:0]   ftot_sum;
   logic [anb2l_pkg::FRAME_BITS-1:0] ftot_new;

   always_comb begin
      // header byte opens the NAL
      st_h  = st_cur;
      len_h = len_cur;
      if (st_cur.awaiting) begin
         st_h.ctype    = data_byte[anb2l_pkg::TYPE_BITS-1:0];
         st_h.keep     = ~drop_mask[data_byte[anb2l_pkg::TYPE_BITS-1:0]];
         st_h.in_nal   = 1'b1;
         st_h.awaiting = 1'b0;
         st_h.held     = 2'd0;
         len_h         = '0;
      end

      is_sc   = (data_byte == anb2l_pkg::START_CODE_BYTE) && st_h.held[1];
      st_m    = st_h;
      zeros_a = 3'd0;
      byte_v  = 1'b0;
      if (data_byte == anb2l_pkg::ZERO_BYTE) begin
         if (st_h.held == anb2l_pkg::HELD_FULL) begin
            zeros_a = {2'b00, st_h.in_nal};
         end else begin
            st_m.held = st_h.held + 2'd1;
         end
      end else if (is_sc) begin
         st_m.in_nal   = 1'b0;
         st_m.keep     = 1'b0;
         st_m.awaiting = 1'b1;
         st_m.held     = 2'd0;
      end else begin
         if (st_h.in_nal) begin
            zeros_a = {1'b0, st_h.held};
            byte_v  = 1'b1;
         end
         st_m.held = 2'd0;
      end

      // frame end flushes held zeros into the open NAL
      zeros_b   = (frame_last && !is_sc && st_h.in_nal) ? {1'b0, st_m.held} : 3'd0;
      zeros_tot = zeros_a + zeros_b;
      inc       = zeros_tot + {2'b00, byte_v};
      len_sum   = {1'b0, len_h} + (LEN_BITS+1)'(inc);
      len_new   = len_sum[LEN_BITS] ? {LEN_BITS{1'b1}} : len_sum[LEN_BITS-1:0];

      close_kept = st_h.in_nal && st_h.keep && (is_sc || frame_last);
      close_len  = is_sc ? len_h : len_new;
      ftot_sum   = SUM_BITS'(ftot_cur) + SUM_BITS'(anb2l_pkg::PREFIX_BYTES)
                 + SUM_BITS'(close_len);
      if (!close_kept) begin
         ftot_new = ftot_cur;
      end else if (ftot_sum > SUM_BITS'(anb2l_pkg::FRAME_MAX)) begin
         ftot_new = anb2l_pkg::FRAME_MAX;
      end else begin
         ftot_new = ftot_sum[anb2l_pkg::FRAME_BITS-1:0];
      end

      bnd_ctl.zero_cnt = st_h.keep ? zeros_tot : 3'd0;
      bnd_ctl.byte_vld = byte_v && st_h.keep;
      bnd_ctl.rec_vld  = close_kept || frame_last;
      bnd_ctl.rec_fe   = frame_last;
      bnd_len  = close_kept ? close_len : '0;
      bnd_type = close_kept ? st_h.ctype : '0;
      bnd_fs   = frame_last ? ftot_new : '0;

      if (frame_last) begin
         st_nxt   = '0;
         len_nxt  = '0;
         ftot_nxt = '0;
      end else begin
         st_nxt   = st_m;
         len_nxt  = is_sc ? '0 : len_new;
         ftot_nxt = ftot_new;
      end
   end
endmodule
`default_nettype wire

/* rtl/anb2l_outq.sv */
// Result register: holds the results of one byte and hands them out one per
// transaction (zeros, then the byte, then the record). Uses anb2l_pkg.
`default_nettype none
module anb2l_outq #(
   parameter int LEN_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire anb2l_pkg::bundle_ctl_type           ctl_in,
   input  wire logic [7:0]                          byte_in,
   input  wire logic [LEN_BITS-1:0]                 len_in,
   input  wire logic [anb2l_pkg::TYPE_BITS-1:0]     type_in,
   input  wire logic [anb2l_pkg::FRAME_BITS-1:0]    fs_in,
   output logic                                     can_load,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_kind,
   output logic [7:0]                               rsp_out_byte,
   output logic [LEN_BITS-1:0]                      rsp_nal_length,
   output logic [anb2l_pkg::TYPE_BITS-1:0]          rsp_nal_kind_code,
   output logic                                     rsp_frame_end,
   output logic [anb2l_pkg::FRAME_BITS-1:0]         rsp_frame_size,
   output logic                                     rsp_last
);
   anb2l_pkg::bundle_ctl_type ctl_ff, ctl_in_nxt;
   logic [7:0]                          byte_ff;
   logic [LEN_BITS-1:0]                 len_ff;
   logic [anb2l_pkg::TYPE_BITS-1:0]     type_ff;
   logic [anb2l_pkg::FRAME_BITS-1:0]    fs_ff;
   logic                                zero_now;

   assign zero_now  = (ctl_ff.zero_cnt != 3'd0);
   assign rsp_valid = zero_now || ctl_ff.byte_vld || ctl_ff.rec_vld;
   assign rsp_last  = (ctl_ff.zero_cnt == 3'd1 && !ctl_ff.byte_vld && !ctl_ff.rec_vld)
                   || (!zero_now && ctl_ff.byte_vld && !ctl_ff.rec_vld)
                   || (!zero_now && !ctl_ff.byte_vld && ctl_ff.rec_vld);
   assign can_load  = !rsp_valid || (rsp_last && !rsp_stall);

   always_comb begin
      rsp_kind          = 1'b0;
      rsp_out_byte      = 8'h00;
      rsp_nal_length    = '0;
      rsp_nal_kind_code = '0;
      rsp_frame_end     = 1'b0;
      rsp_frame_size    = '0;
      if (zero_now) begin
         rsp_out_byte = anb2l_pkg::ZERO_BYTE;
      end else if (ctl_ff.byte_vld) begin
         rsp_out_byte = byte_ff;
      end else if (ctl_ff.rec_vld) begin
         rsp_kind          = 1'b1;
         rsp_nal_length    = len_ff;
         rsp_nal_kind_code = type_ff;
         rsp_frame_end     = ctl_ff.rec_fe;
         rsp_frame_size    = fs_ff;
      end
   end

   always_comb begin
      ctl_in_nxt = ctl_ff;
      if (load) begin
         ctl_in_nxt = ctl_in;
      end else if (rsp_valid && !rsp_stall) begin
         if (zero_now) begin
            ctl_in_nxt.zero_cnt = ctl_ff.zero_cnt - 3'd1;
         end else if (ctl_ff.byte_vld) begin
            ctl_in_nxt.byte_vld = 1'b0;
         end else begin
            ctl_in_nxt.rec_vld = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         fs_ff   <= fs_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/annexb_to_length_prefixed_nal_core.sv */
// Annex B to length-prefixed NAL converter, top level: CSR, parser state,
// step logic (anb2l_step) and result register (anb2l_outq). Uses anb2l_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  data_byte, frame_last
//   rsp      out        rsp_valid / rsp_stall  kind, out_byte, nal_length,
//                                              nal_kind_code, frame_end,
//                                              frame_size, last
//   csr      in/out     APB psel/penable       drop_type_mask at offset 0
//
// A byte is parsed in the cycle it is accepted and its results land in the
// result register at that edge. A byte yielding at most one result sustains
// one transaction per cycle while rsp_stall is low; a byte yielding more (up
// to five) occupies the result register, and the next byte waits, until its last is taken.
// Reset is synchronous: parser state clears, the drop mask returns to 0x380.
// rsp_stall holds the current result in place and raises req_stall while it lasts.
`default_nettype none
`include "annexb_to_length_prefixed_nal_core_defines.svh"
module annexb_to_length_prefixed_nal_core #(
   parameter int LEN_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // byte input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_frame_last,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_kind,
   output logic [7:0]                               rsp_out_byte,
   output logic [LEN_BITS-1:0]                      rsp_nal_length,
   output logic [anb2l_pkg::TYPE_BITS-1:0]          rsp_nal_kind_code,
   output logic                                     rsp_frame_end,
   output logic [anb2l_pkg::FRAME_BITS-1:0]         rsp_frame_size,
   output logic                                     rsp_last,
   // configuration
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [anb2l_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [anb2l_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [anb2l_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                     csr_pready
);
   logic [anb2l_pkg::CSR_DATA_BITS-1:0] mask_ff, mask_in;
   anb2l_pkg::nal_state_type            st_ff, st_in;
   logic [LEN_BITS-1:0]                 len_ff, len_in;
   logic [anb2l_pkg::FRAME_BITS-1:0]    ftot_ff, ftot_in;

   anb2l_pkg::bundle_ctl_type           bnd_ctl;
   logic [LEN_BITS-1:0]                 bnd_len;
   logic [anb2l_pkg::TYPE_BITS-1:0]     bnd_type;
   logic [anb2l_pkg::FRAME_BITS-1:0]    bnd_fs;
   logic                                can_load;
   logic                                req_take;
   logic                                csr_sel_mask;
   logic                                st_clear;

   // CSR: single register, decoded on the word index above the byte lanes
   assign csr_pready   = 1'b1;
   assign csr_sel_mask = (csr_paddr[anb2l_pkg::CSR_ADDR_BITS-1] == anb2l_pkg::CSR_IDX_DROP_MASK);
   assign csr_prdata   = csr_sel_mask ? mask_ff : '0;
   assign mask_in      = (csr_psel && csr_penable && csr_pwrite && csr_sel_mask)
                       ? csr_pwdata : mask_ff;

   // accept a byte whenever the result register is free or frees this cycle
   assign req_stall = !can_load;
   assign req_take  = req_valid && can_load;

   anb2l_step #(
      .LEN_BITS (LEN_BITS)
   ) u_step (
      .data_byte  (req_data_byte),
      .frame_last (req_frame_last),
      .drop_mask  (mask_ff),
      .st_cur     (st_ff),
      .len_cur    (len_ff),
      .ftot_cur   (ftot_ff),
      .st_nxt     (st_in),
      .len_nxt    (len_in),
      .ftot_nxt   (ftot_in),
      .bnd_ctl    (bnd_ctl),
      .bnd_len    (bnd_len),
      .bnd_type   (bnd_type),
      .bnd_fs     (bnd_fs)
   );

   anb2l_outq #(
      .LEN_BITS (LEN_BITS)
   ) u_outq (
      .clock             (clock),
      .reset             (reset),
      .load              (req_take),
      .ctl_in            (bnd_ctl),
      .byte_in           (req_data_byte),
      .len_in            (bnd_len),
      .type_in           (bnd_type),
      .fs_in             (bnd_fs),
      .can_load          (can_load),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_nal_length    (rsp_nal_length),
      .rsp_nal_kind_code (rsp_nal_kind_code),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_last          (rsp_last)
   );

   // parser state advances only on an accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= anb2l_pkg::DROP_MASK_RESET;
         st_ff   <= '0;
         len_ff  <= '0;
         ftot_ff <= '0;
      end else begin
         mask_ff <= mask_in;
         if (req_take) begin
            st_ff   <= st_in;
            len_ff  <= len_in;
            ftot_ff <= ftot_in;
         end
      end
   end

   assign st_clear = (st_ff == '0) && (len_ff == '0) && (ftot_ff == '0);

   // a byte enters only when the pending results finish in the same cycle
   `ANB2L_ASSERT_NOW(a_take_frees, clock, reset, req_take && rsp_valid, rsp_last && !rsp_stall)
   // a frame-closing record is always the final result of its byte
   `ANB2L_ASSERT_NOW(a_fe_is_last, clock, reset, rsp_valid && rsp_frame_end, rsp_kind && rsp_last)
   // the frame's final byte returns the parser to its reset state
   `ANB2L_ASSERT_NEXT(a_frame_clear, clock, reset, req_take && req_frame_last, st_clear)
endmodule
`default_nettype wire

/* dv/tb_annexb_to_length_prefixed_nal_core.sv */
// Self-checking bench for annexb_to_length_prefixed_nal_core: Annex B frames in,
// payload bytes and NAL length records out, checked against an in-bench predictor.
// Depends on anb2l_pkg and the core RTL only.
module tb_annexb_to_length_prefixed_nal_core;
   import anb2l_pkg::*;

   localparam int LEN_BITS      = 24;
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 4;    // parser works in the accept cycle
   localparam int TAIL_CYCLES   = 20;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_RECORD  = 1'b1;

   // Byte address of the drop mask: register index above the byte lanes
   localparam logic [CSR_ADDR_BITS-1:0] DROP_MASK_ADDR = {CSR_IDX_DROP_MASK, 2'b00};

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic                  kind;
      logic [7:0]            out_byte;
      logic [LEN_BITS-1:0]   nal_length;
      logic [TYPE_BITS-1:0]  nal_kind_code;
      logic                  frame_end;
      logic [FRAME_BITS-1:0] frame_size;
      logic                  last;
   } nal_result_type;

   // Clock, reset and block inputs: every input known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid      = 1'b0;
   logic [7:0]               req_data_byte  = 8'h00;
   logic                     req_frame_last = 1'b0;
   logic                     rsp_stall      = 1'b0;
   logic                     csr_psel       = 1'b0;
   logic                     csr_penable    = 1'b0;
   logic                     csr_pwrite     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr      = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata     = '0;

   logic                     req_stall;
   logic                     rsp_valid;
   logic                     rsp_kind;
   logic [7:0]               rsp_out_byte;
   logic [LEN_BITS-1:0]      rsp_nal_length;
   logic [TYPE_BITS-1:0]     rsp_nal_kind_code;
   logic                     rsp_frame_end;
   logic [FRAME_BITS-1:0]    rsp_frame_size;
   logic                     rsp_last;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Predictor state: a private copy of the parser and of the drop mask
   logic [CSR_DATA_BITS-1:0] drop_mask = DROP_MASK_RESET;
   logic [1:0]               held_zero_cnt;
   logic                     in_nal;
   logic                     want_header;
   logic                     keep_nal;
   logic [TYPE_BITS-1:0]     nal_type;
   logic [LEN_BITS-1:0]      nal_len;
   logic [FRAME_BITS-1:0]    frame_bytes;

   nal_result_type expected_q[$];   // results still owed by the block, oldest first

   int unsigned accepted_items  = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;
   int unsigned rsp_hold_cycles = 0;   // long receiver hold-off, served by the pacer
   logic        idling_on       = 1'b0;

   annexb_to_length_prefixed_nal_core #(
      .LEN_BITS(LEN_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_frame_last    (req_frame_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_nal_length    (rsp_nal_length),
      .rsp_nal_kind_code (rsp_nal_kind_code),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void clear_frame_state();
      held_zero_cnt = '0;
      in_nal        = 1'b0;
      want_header   = 1'b0;
      keep_nal      = 1'b0;
      nal_type      = '0;
      nal_len       = '0;
      frame_bytes   = '0;
   endfunction

   function automatic void queue_result(input logic kind, input logic [7:0] data,
                                        input logic [LEN_BITS-1:0] len,
                                        input logic [TYPE_BITS-1:0] nal_kind,
                                        input logic fe, input logic [FRAME_BITS-1:0] fsize);
      nal_result_type r;
      r.kind          = kind;
      r.out_byte      = data;
      r.nal_length    = len;
      r.nal_kind_code = nal_kind;
      r.frame_end     = fe;
      r.frame_size    = fsize;
      r.last          = 1'b0;
      expected_q = {expected_q, r};
   endfunction

   // Count one NAL byte (saturating) and pass it on if the NAL is kept
   function automatic void count_payload(input logic [7:0] data);
      if (nal_len != '1)
         nal_len++;
      if (keep_nal)
         queue_result(KIND_PAYLOAD, data, '0, '0, 1'b0, '0);
   endfunction

   // Release the zeros held back: they turned out to be payload
   function automatic void flush_held_zeros();
      while (held_zero_cnt != 0) begin
         count_payload(ZERO_BYTE);
         held_zero_cnt--;
      end
   endfunction

   // Close the open NAL; a record comes only for a kept NAL
   function automatic logic close_nal_record(input logic at_frame_end);
      logic [FRAME_BITS:0] sum;
      if (!keep_nal)
         return 1'b0;
      sum = frame_bytes + PREFIX_BYTES + nal_len;
      frame_bytes = (sum > FRAME_MAX) ? FRAME_MAX : sum[FRAME_BITS-1:0];
      queue_result(KIND_RECORD, 8'h00, nal_len, nal_type, at_frame_end,
                   at_frame_end ? frame_bytes : '0);
      return 1'b1;
   endfunction

   // Work out every result that one accepted byte causes
   function automatic void predict_byte(input logic [7:0] data, input logic fl);
      logic        frame_closed = 1'b0;
      int unsigned owed_before  = expected_q.size();

      // The byte after a start code is the NAL header
      if (want_header) begin
         nal_type      = data[TYPE_BITS-1:0];
         keep_nal      = !drop_mask[nal_type];
         in_nal        = 1'b1;
         want_header   = 1'b0;
         nal_len       = '0;
         held_zero_cnt = '0;
      end

      if (data == ZERO_BYTE) begin
         // Hold up to three zeros; a fourth pushes the oldest out as payload
         if (held_zero_cnt == HELD_FULL) begin
            if (in_nal)
               count_payload(ZERO_BYTE);
         end else begin
            held_zero_cnt++;
         end
      end else if (data == START_CODE_BYTE && held_zero_cnt >= 2) begin
         // Start code: trim it, close the open NAL and await a header
         if (in_nal)
            frame_closed = close_nal_record(fl) && fl;
         in_nal        = 1'b0;
         keep_nal      = 1'b0;
         want_header   = 1'b1;
         nal_len       = '0;
         held_zero_cnt = '0;
      end else begin
         if (in_nal) begin
            flush_held_zeros();
            count_payload(data);
         end
         held_zero_cnt = '0;
      end

      if (fl) begin
         // Trailing zeros belong to the open NAL; the frame total needs a record
         if (in_nal) begin
            flush_held_zeros();
            if (close_nal_record(1'b1))
               frame_closed = 1'b1;
         end
         if (!frame_closed)
            queue_result(KIND_RECORD, 8'h00, '0, '0, 1'b1, frame_bytes);
         clear_frame_state();
      end

      // Mark the final result of this byte
      if (expected_q.size() > owed_before)
         expected_q[$].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic note_mismatch(input string what);
      if (mismatch_count < 10)
         $display("[%0d] mismatch: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Compare every accepted result with the oldest one owed
   always @(posedge clock) begin : result_checker
      nal_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result kind=%0d byte=%02h len=%0d type=%0d",
                                    rsp_kind, rsp_out_byte, rsp_nal_length,
                                    rsp_nal_kind_code));
         end else begin
            want = expected_q.pop_front();
            if (rsp_kind !== want.kind || rsp_out_byte !== want.out_byte ||
                rsp_nal_length !== want.nal_length ||
                rsp_nal_kind_code !== want.nal_kind_code ||
                rsp_frame_end !== want.frame_end || rsp_frame_size !== want.frame_size ||
                rsp_last !== want.last) begin
               note_mismatch($sformatf({"expected kind=%0d byte=%02h len=%0d type=%0d ",
                                        "fe=%0d size=%0d last=%0d, got kind=%0d byte=%02h ",
                                        "len=%0d type=%0d fe=%0d size=%0d last=%0d"},
                                       want.kind, want.out_byte, want.nal_length,
                                       want.nal_kind_code, want.frame_end, want.frame_size,
                                       want.last, rsp_kind, rsp_out_byte, rsp_nal_length,
                                       rsp_nal_kind_code, rsp_frame_end, rsp_frame_size,
                                       rsp_last));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver pacing
   // ------------------------------------------------------------------

   // Stall in random bursts while idling is on; serve a long hold-off on request
   always begin : rsp_pacer
      @(posedge clock);
      if (rsp_hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         repeat (rsp_hold_cycles) @(posedge clock);
         rsp_hold_cycles = 0;
         rsp_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 13)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Sender and configuration
   // ------------------------------------------------------------------

   // Offer one byte and hold it until the block takes the transaction
   task automatic push_byte(input logic [7:0] data, input logic fl);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_frame_last <= fl;
      do
         @(posedge clock);
      while (req_stall);
      predict_byte(data, fl);
      accepted_items++;
   endtask

   // Send a whole frame, frame_last on its final byte
   task automatic send_frame(input byte_q_type frame);
      foreach (frame[i])
         push_byte(frame[i], i == frame.size() - 1);
   endtask

   // Drop valid, wait for every owed result, then let the block settle
   task automatic drain_results(input int unsigned settle);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write the drop mask over APB, then read it back
   task automatic write_drop_mask(input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DROP_MASK_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      drop_mask = value;
      // Read phase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value)
         note_mismatch($sformatf("drop mask read %08h, wrote %08h", readback, value));
   endtask

   // Byte mix rich in zeros and ones, so start codes and zero runs turn up often
   function automatic logic [7:0] random_stream_byte();
      int unsigned pick = $urandom_range(0, 99);
      if (pick < 35)
         return 8'h00;
      if (pick < 45)
         return 8'h01;
      if (pick < 50)
         return 8'h03;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly well-formed frames with random content; the rest is raw noise
   task automatic send_random_frame();
      byte_q_type  frame;
      int unsigned body_len;
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 20)) frame = {frame, random_stream_byte()};
      end else begin
         // Junk ahead of the first start code
         repeat ($urandom_range(0, 3)) frame = {frame, random_stream_byte()};
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
               frame = {frame, 8'h00};
            frame = {frame, 8'h00, 8'h00, 8'h01};
            frame = {frame, ($urandom_range(0, 9) == 0) ? 8'h00
                                                        : 8'($urandom_range(0, 255))};
            body_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(0, 10);
            repeat (body_len) frame = {frame, random_stream_byte()};
         end
         // Now and then end the frame on a bare start code
         if ($urandom_range(0, 7) == 0)
            frame = {frame, 8'h00, 8'h00, 8'h01};
      end
      send_frame(frame);
   endtask

   task automatic run_random_items(input int unsigned item_goal);
      int unsigned start = accepted_items;
      while (accepted_items - start < item_goal)
         send_random_frame();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-built frames under the reset mask (types 7, 8, 9 dropped)
   task automatic test_directed_special_cases();
      // Leading junk, 3-byte start code, kept type 5, a run of four zeros,
      // a start code right after a nonzero byte, zero header giving a
      // zero-length NAL, and trailing zeros released at frame end
      send_frame({8'h55, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                  8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00});
      // 4-byte start code and a dropped final NAL: separate frame-end record
      send_frame({8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF});
      // No start code at all
      send_frame({8'h12});
      // Start code as the very last bytes
      send_frame({8'h00, 8'h00, 8'h01});
      drain_results(SETTLE_CYCLES);
   endtask

   task automatic test_reset_mask_random();
      idling_on = 1'b1;
      run_random_items(40);
      drain_results(SETTLE_CYCLES);
   endtask

   // Keep every type; idle for the first half, run flat out for the second
   task automatic test_keep_all_random();
      write_drop_mask('0);
      idling_on = 1'b1;
      run_random_items(15);
      idling_on = 1'b0;
      run_random_items(15);
      drain_results(SETTLE_CYCLES);
   endtask

   // Hold the receiver off while a long kept NAL streams in, so the block backs up
   task automatic test_output_backpressure();
      byte_q_type frame;
      frame = {8'h00, 8'h00, 8'h01, 8'h65};
      repeat (48) frame = {frame, 8'($urandom_range(2, 255))};
      idling_on = 1'b0;
      rsp_hold_cycles = 150;
      send_frame(frame);
      drain_results(SETTLE_CYCLES);
   endtask

   // Drop every type: only frame-end records should come out
   task automatic test_drop_all_random();
      write_drop_mask('1);
      idling_on = 1'b1;
      run_random_items(15);
      drain_results(SETTLE_CYCLES);
   endtask

   // Random masks; the last setting runs without idling on either side
   task automatic test_random_masks();
      for (int k = 0; k < 3; k++) begin
         write_drop_mask($urandom);
         idling_on = (k < 2);
         run_random_items(20);
         drain_results(SETTLE_CYCLES);
      end
   endtask

   initial begin
      clear_frame_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_special_cases();
      test_reset_mask_random();
      test_keep_all_random();
      test_output_backpressure();
      test_drop_all_random();
      test_random_masks();

      drain_results(TAIL_CYCLES);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/anb2l_pkg.sv
rtl/anb2l_step.sv
rtl/anb2l_outq.sv
rtl/annexb_to_length_prefixed_nal_core.sv
dv/tb_annexb_to_length_prefixed_nal_core.sv
